/* rtl/yrgb_pkg.sv */
// Shared types and constants of the 4:2:0 to RGB stream converter.
package yrgb_pkg;

  localparam int unsigned YRGB_MAX_WIDTH = 2048;
  localparam int unsigned YRGB_MAX_ROWS  = 4096;

  // Q16 conversion coefficients
  localparam logic signed [17:0] KRV = 18'sd89831;
  localparam logic signed [17:0] KGV = 18'sd45744;
  localparam logic signed [17:0] KGU = 18'sd22127;
  localparam logic signed [17:0] KBU = 18'sd113538;

  localparam logic [7:0] CHROMA_BIAS = 8'd128;
  localparam logic [7:0] SCALE_NUM   = 8'd220;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ALPHA_ENABLE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } in_data_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        line_end;
    logic        frame_end;
  } out_data_t;

  // Position flags that travel down the pipeline with each pixel
  typedef struct packed {
    logic line_end;
    logic frame_end;
  } pix_flags_t;

endpackage

/* rtl/yuv420_to_rgb_stream.sv */
// Top level of the streaming 4:2:0 YUV to RGB converter with its chroma line store.
//
//   channel | ports                                   | carries
//   --------+-----------------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data             | one pixel request: Y, U, V
//   output  | out_valid, out_stall, out_data          | packed ABGR word, row/frame end
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | width, height, alpha enable
//
// One pixel per cycle while out_stall does not hold a result; an accepted request passes
// the line store read, products and clamp registers, then is scaled and packed into the output register.
// A result held by out_stall freezes the whole pipeline and raises in_stall in the
// same cycle; while the output register is empty the pipeline keeps advancing.
// Reset clears the counters and the pipeline valids; the line store has no reset
// and is filled by the first row of each row pair before the second row reads it.
// cfg_ready is always high; the user must rewrite registers only while the block is idle (unchecked).
module yuv420_to_rgb_stream #(
  parameter int unsigned MAX_WIDTH = yrgb_pkg::YRGB_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  yrgb_pkg::in_data_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output yrgb_pkg::out_data_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  yrgb_pkg::cfg_index_t cfg_index,
  input  logic [12:0]          cfg_data
);
  import yrgb_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);    // column counter bits
  localparam int unsigned AW    = CW - 1;               // line store address bits
  localparam int unsigned DEPTH = MAX_WIDTH / 2;
  localparam int unsigned EW    = (CW >= 12) ? CW + 1 : 13; // width compare bits

  // configuration registers
  logic [11:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic        alpha_enable_r;

  // position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;

  logic [EW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic          last_col, last_row;
  logic          adv, accept, wr_en;
  logic [AW-1:0] slot;

  // line store: U in 7:0, V in 15:8
  logic [15:0] line_mem [DEPTH];
  logic [15:0] rd_r;

  // stage 1 registers
  logic        vld1_r;
  logic [7:0]  y1_r;
  logic [15:0] uv1_r;
  logic        wr1_r;
  pix_flags_t  f1_r, f1_nxt;
  logic [15:0] entry;
  logic        conv_vld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 12'd640;
      frame_height_r <= 13'd480;
      alpha_enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[11:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        CFG_ALPHA_ENABLE: alpha_enable_r <= cfg_data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Advance the whole pipeline whenever the output register is free or draining.
  assign adv      = !conv_vld || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Clamp the configured frame size into the legal range.
  always_comb begin
    if (frame_width_r < 12'd2) begin
      w_eff = EW'(2);
    end else if (EW'(frame_width_r) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(frame_width_r);
    end
    if (frame_height_r == 13'd0) begin
      h_eff = 13'd1;
    end else if (frame_height_r > 13'(YRGB_MAX_ROWS)) begin
      h_eff = 13'(YRGB_MAX_ROWS);
    end else begin
      h_eff = frame_height_r;
    end
  end

  // A counter at or past the last position ends the row or frame.
  assign last_col = (EW'(col_r) + EW'(1)) >= w_eff;
  assign last_row = (13'(row_r) + 13'd1) >= h_eff;

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? 12'd0 : row_r + 12'd1;
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
    f1_nxt.line_end  = last_col;
    f1_nxt.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Even row, even column: store the chroma pair; every pixel reads its pair back.
  assign slot  = col_r[CW-1:1];
  assign wr_en = !row_r[0] && !col_r[0];

  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en) begin
        line_mem[slot] <= {in_data.chroma_v, in_data.chroma_u};
      end
      rd_r <= line_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y1_r  <= in_data.luma;
      uv1_r <= {in_data.chroma_v, in_data.chroma_u};
      wr1_r <= wr_en;
      f1_r  <= f1_nxt;
    end
  end

  // Forward the pair written in the same cycle as the read.
  assign entry = wr1_r ? uv1_r : rd_r;

  yrgb_convert u_convert (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_vld       (vld1_r),
    .luma         (y1_r),
    .entry        (entry),
    .flags        (f1_r),
    .alpha_enable (alpha_enable_r),
    .out_vld      (conv_vld),
    .out_data     (out_data)
  );

  assign out_valid = conv_vld;

endmodule

/* rtl/yrgb_convert.sv */
// Color conversion pipeline: products, clamp, scale and pack.
module yrgb_convert (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [7:0]          luma,
  input  logic [15:0]         entry,
  input  yrgb_pkg::pix_flags_t flags,
  input  logic                alpha_enable,
  output logic                out_vld,
  output yrgb_pkg::out_data_t out_data
);
  import yrgb_pkg::*;

  logic signed [8:0]  du, dv;
  logic signed [26:0] prv_r, pgv_r, pgu_r, pbu_r;
  logic signed [26:0] prv_nxt, pgv_nxt, pgu_nxt, pbu_nxt;
  logic [7:0]         y2_r;
  pix_flags_t         f2_r, f3_r;
  logic               vld2_r, vld3_r, vld_out_r;
  logic signed [26:0] ys, sum_r, sum_g, sum_b;
  logic [7:0]         cr_r, cg_r, cb_r;
  logic [7:0]         cr_nxt, cg_nxt, cb_nxt;
  logic [15:0]        mr, mg, mb;
  out_data_t          out_r, out_nxt;

  function automatic logic [7:0] clamp_ch(input logic signed [26:0] s);
    logic [7:0] c;
    if (s[26]) begin
      c = 8'd0;
    end else if (|s[25:24]) begin
      c = 8'hFF;
    end else begin
      c = s[23:16];
    end
    return c;
  endfunction

  // stage 2: chroma offsets and products
  always_comb begin
    du = $signed({1'b0, entry[7:0]})  - $signed({1'b0, CHROMA_BIAS});
    dv = $signed({1'b0, entry[15:8]}) - $signed({1'b0, CHROMA_BIAS});
    prv_nxt = 27'(KRV) * 27'(dv);
    pgv_nxt = 27'(KGV) * 27'(dv);
    pgu_nxt = 27'(KGU) * 27'(du);
    pbu_nxt = 27'(KBU) * 27'(du);
  end

  // stage 3: sums and clamp
  always_comb begin
    ys     = $signed({3'b000, y2_r, 16'h0000});
    sum_r  = ys + prv_r;
    sum_g  = ys - pgv_r - pgu_r;
    sum_b  = ys + pbu_r;
    cr_nxt = clamp_ch(sum_r);
    cg_nxt = clamp_ch(sum_g);
    cb_nxt = clamp_ch(sum_b);
  end

  // stage 4: 220/256 scale and pack
  always_comb begin
    mr = cr_r * SCALE_NUM;
    mg = cg_r * SCALE_NUM;
    mb = cb_r * SCALE_NUM;
    out_nxt.pixel_word = {(alpha_enable ? ALPHA_OPAQUE : 8'h00), mb[15:8], mg[15:8], mr[15:8]};
    out_nxt.line_end   = f3_r.line_end;
    out_nxt.frame_end  = f3_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      vld_out_r <= 1'b0;
    end else if (adv) begin
      vld2_r    <= in_vld;
      vld3_r    <= vld2_r;
      vld_out_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prv_r <= prv_nxt;
      pgv_r <= pgv_nxt;
      pgu_r <= pgu_nxt;
      pbu_r <= pbu_nxt;
      y2_r  <= luma;
      f2_r  <= flags;
      cr_r  <= cr_nxt;
      cg_r  <= cg_nxt;
      cb_r  <= cb_nxt;
      f3_r  <= f2_r;
      out_r <= out_nxt;
    end
  end

  assign out_vld  = vld_out_r;
  assign out_data = out_r;

endmodule
